/* rtl/mctt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctt_pkg - shared types and constants of the MIDI clock tempo tracker
// Status byte codes, register indexes, result codes, sequencer states and
// the fixed-point constants of the tempo and phase arithmetic.
// ----------------------------------------------------------------------------
package mctt_pkg;

	localparam int LOCK_BEATS_DEF = 12;

	localparam int TIME_W  = 32;
	localparam int TEMPO_W = 16;
	localparam int SEQ_W   = 8;
	localparam int TICK_W  = 5;
	localparam int ACQ_W   = 4;
	localparam int PHASE_W = 15;
	localparam int SB_W    = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0]  TICKS_PER_BEAT  = 5'd24;
	localparam logic [TIME_W-1:0]  MIN_MS_PER_BEAT = 32'd225;
	localparam logic [TIME_W-1:0]  MAX_MS_PER_BEAT = 32'd3000;
	localparam logic [TIME_W-1:0]  TEMPO_NUMERATOR = 32'd15339169;
	localparam logic [TEMPO_W-1:0] TEMPO_CEILING   = 16'hFFFF;
	localparam logic [8:0]         PHASE_SCALE     = 9'd280;
	localparam logic [ACQ_W-1:0]   ACQ_MIN_BEATS   = 4'd2;

	localparam logic [SB_W-1:0] SB_CLOCK    = 8'hF8;
	localparam logic [SB_W-1:0] SB_START    = 8'hFA;
	localparam logic [SB_W-1:0] SB_CONTINUE = 8'hFB;
	localparam logic [SB_W-1:0] SB_STOP     = 8'hFC;
	localparam logic [SB_W-1:0] SB_SENSING  = 8'hFE;
	localparam logic [SB_W-1:0] SB_QFRAME   = 8'hF1;

	localparam logic [CFG_IDX_W-1:0] REG_ABSORB_CLOCK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_SENSING  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_QFRAME   = 2'd2;

	typedef enum logic [1:0] {
		DISP_ABSORB = 2'd0,
		DISP_DROP   = 2'd1,
		DISP_SEND   = 2'd2,
		DISP_PHASE  = 2'd3
	} disp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_DIV,
		S_MSET,
		S_MUL,
		S_DONE
	} state_t;

endpackage

/* rtl/midi_clock_tempo_tracker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker - MIDI clock tempo tracker, master side
// Filters and numbers MIDI status bytes, absorbs clock and transport bytes,
// estimates tempo in Q8.8 with a bit-serial divider and answers beat phase
// with a bit-serial shift-add multiplier.
// ----------------------------------------------------------------------------
//
//  channel  handshake               payload
//  -------  ----------------------  ------------------------------------------
//  in       in_valid / in_stall     command, status_byte, now_ms
//  out      out_valid / out_stall   disposition, sequence_res, tempo_q88,
//                                   playing, phase15
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data (bit 0 used)
//
//  One beat at a time. A beat passes decode and state update (S_EXEC),
//  the multiplier setup (S_MSET), the phase multiplier (S_MUL, one bit of
//  the tempo per cycle) and the load of the output register (S_DONE).
//  A clock tick that closes a beat and refreshes the estimate also passes the divider
//  (S_DIV, one quotient bit per cycle) between decode and the setup.
//  in_stall is high from accept until the result moves to the output
//  register; the output register frees the input side, so a new beat is
//  taken while the last result waits on out_stall. cfg_ready is always high.
//  Reset clears all tracking state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker #(
	parameter int LOCK_BEATS = mctt_pkg::LOCK_BEATS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input beats
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [mctt_pkg::SB_W-1:0]       status_byte,
	input  logic [mctt_pkg::TIME_W-1:0]     now_ms,
	// results
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [1:0]                      disposition,
	output logic [mctt_pkg::SEQ_W-1:0]      sequence_res,
	output logic [mctt_pkg::TEMPO_W-1:0]    tempo_q88,
	output logic                            playing,
	output logic [mctt_pkg::PHASE_W-1:0]    phase15,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [mctt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic                            cfg_data
);
	import mctt_pkg::*;

	// Numerator of the tempo division is TEMPO_NUMERATOR * beats, beats up
	// to LOCK_BEATS; the divider walks one numerator bit per cycle.
	localparam int NUM_W = $clog2(TEMPO_NUMERATOR * LOCK_BEATS + 1);
	localparam int CNT_N = (NUM_W > TEMPO_W) ? NUM_W : TEMPO_W;
	localparam int CNT_W = $clog2(CNT_N);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t state_q, state_d;

	// captured beat (payload, no reset)
	logic                cmd_q;
	logic [SB_W-1:0]     sb_q;
	logic [TIME_W-1:0]   now_q;

	// configuration
	logic absorb_q, drop_sensing_q, drop_qframe_q;

	// tracking state
	logic                have_clock_q;
	logic [TICK_W-1:0]   tick_q;
	logic [TIME_W-1:0]   anchor_q;
	logic [TIME_W-1:0]   window_q;
	logic [ACQ_W-1:0]    acq_q;
	logic [TEMPO_W-1:0]  tempo_q;
	logic                play_q;
	logic [SEQ_W-1:0]    seq_q;
	disp_t               disp_q;

	// serial divider and multiplier
	logic [TIME_W-1:0]   rem_q;
	logic [NUM_W-1:0]    num_q;
	logic [TIME_W-1:0]   win_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W-1:0]   mcand_q;
	logic [TEMPO_W-1:0]  mplier_q;
	logic [TIME_W-1:0]   acc_q;

	// output register
	logic                out_valid_q;
	disp_t               out_disp_q;
	logic [SEQ_W-1:0]    out_seq_q;
	logic [TEMPO_W-1:0]  out_tempo_q;
	logic                out_play_q;
	logic [PHASE_W-1:0]  out_phase_q;

	// ------------------------------------------------------------------
	// Handshake
	// ------------------------------------------------------------------
	logic in_acc, cfg_wr, out_free;

	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign out_free  = ~out_valid_q | ~out_stall;

	assign out_valid    = out_valid_q;
	assign disposition  = out_disp_q;
	assign sequence_res = out_seq_q;
	assign tempo_q88    = out_tempo_q;
	assign playing      = out_play_q;
	assign phase15      = out_phase_q;

	// ------------------------------------------------------------------
	// Decode and state update of the captured beat (S_EXEC)
	// ------------------------------------------------------------------
	logic                is_clock, is_start, is_cont, is_stop, absorbed, dropped;
	logic [TICK_W-1:0]   tick_base, tick_inc;
	logic [ACQ_W-1:0]    acq_base, acq_inc;
	logic [TIME_W-1:0]   anchor_base, window_base, win;
	logic [TIME_W-1:0]   win_lo, win_hi;
	logic                beat_done, acq_open, est_go;
	disp_t               disp_d;

	always_comb begin
		is_clock = (sb_q == SB_CLOCK);
		is_start = (sb_q == SB_START);
		is_cont  = (sb_q == SB_CONTINUE);
		is_stop  = (sb_q == SB_STOP);
		absorbed = absorb_q & (is_clock | is_start | is_cont | is_stop);
		dropped  = (drop_sensing_q & (sb_q == SB_SENSING)) |
			(drop_qframe_q & (sb_q == SB_QFRAME));

		if (cmd_q) begin
			disp_d = DISP_PHASE;
		end else if (absorbed) begin
			disp_d = DISP_ABSORB;
		end else if (dropped) begin
			disp_d = DISP_DROP;
		end else begin
			disp_d = DISP_SEND;
		end

		// first tick seeds the anchor and the window
		tick_base   = have_clock_q ? tick_q   : '0;
		acq_base    = have_clock_q ? acq_q    : '0;
		anchor_base = have_clock_q ? anchor_q : now_q;
		window_base = have_clock_q ? window_q : now_q;

		tick_inc  = tick_base + 1'b1;
		beat_done = (tick_inc >= TICKS_PER_BEAT);
		acq_open  = (acq_base < ACQ_W'(LOCK_BEATS));
		acq_inc   = acq_base + 1'b1;
		win       = now_q - window_base;
		win_lo    = TIME_W'(acq_inc) * MIN_MS_PER_BEAT;
		win_hi    = TIME_W'(acq_inc) * MAX_MS_PER_BEAT;
		est_go    = (disp_d == DISP_ABSORB) & is_clock & beat_done & acq_open &
			(acq_inc >= ACQ_MIN_BEATS) & (win >= win_lo) & (win <= win_hi);
	end

	// ------------------------------------------------------------------
	// Divider step: restoring, one quotient bit per cycle
	// ------------------------------------------------------------------
	logic [TIME_W:0]     div_shift, div_sub;
	logic                div_ge;
	logic [NUM_W-1:0]    quot;
	logic [TEMPO_W-1:0]  tempo_sat;

	always_comb begin
		div_shift = {rem_q, num_q[NUM_W-1]};
		div_ge    = (div_shift >= {1'b0, win_q});
		div_sub   = div_shift - {1'b0, win_q};
		quot      = {num_q[NUM_W-2:0], div_ge};
		tempo_sat = (|quot[NUM_W-1:TEMPO_W]) ? TEMPO_CEILING : quot[TEMPO_W-1:0];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = est_go ? S_DIV : S_MSET;
			end
			S_DIV: begin
				if (cnt_q == '0) state_d = S_MSET;
			end
			S_MSET: begin
				state_d = S_MUL;
			end
			S_MUL: begin
				if (cnt_q == '0) state_d = S_DONE;
			end
			S_DONE: begin
				// hold until the output register is free
				if (out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Capture of the incoming beat
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			sb_q  <= status_byte;
			now_q <= now_ms;
		end
	end

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			absorb_q       <= 1'b0;
			drop_sensing_q <= 1'b1;
			drop_qframe_q  <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_ABSORB_CLOCK: absorb_q       <= cfg_data;
				REG_DROP_SENSING: drop_sensing_q <= cfg_data;
				REG_DROP_QFRAME:  drop_qframe_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Tracking state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_clock_q <= 1'b0;
			tick_q       <= '0;
			anchor_q     <= '0;
			window_q     <= '0;
			acq_q        <= '0;
			tempo_q      <= '0;
			play_q       <= 1'b0;
			seq_q        <= '0;
			disp_q       <= DISP_ABSORB;
		end else begin
			if (state_q == S_EXEC) begin
				disp_q <= disp_d;
				if (disp_d == DISP_SEND) begin
					seq_q <= seq_q + 1'b1;
				end
				if (disp_d == DISP_ABSORB) begin
					priority if (is_clock) begin
						have_clock_q <= 1'b1;
						if (beat_done) begin
							tick_q   <= '0;
							anchor_q <= now_q;
							window_q <= window_base;
							acq_q    <= acq_open ? acq_inc : acq_base;
						end else begin
							tick_q   <= tick_inc;
							anchor_q <= anchor_base;
							window_q <= window_base;
							acq_q    <= acq_base;
						end
					end else if (is_start) begin
						// re-arm acquisition, keep the estimate
						play_q   <= 1'b1;
						tick_q   <= '0;
						anchor_q <= now_q;
						window_q <= now_q;
						acq_q    <= '0;
					end else if (is_cont) begin
						play_q <= 1'b1;
					end else begin
						play_q <= 1'b0;
					end
				end
			end
			if (state_q == S_DIV && cnt_q == '0) begin
				tempo_q <= tempo_sat;
			end
		end
	end

	// ------------------------------------------------------------------
	// Serial datapath: divider loads in S_EXEC, multiplier in S_MSET
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_EXEC: begin
				rem_q <= '0;
				num_q <= NUM_W'(TEMPO_NUMERATOR * TIME_W'(acq_inc));
				win_q <= win;
				cnt_q <= CNT_W'(NUM_W - 1);
			end
			S_DIV: begin
				rem_q <= div_ge ? div_sub[TIME_W-1:0] : div_shift[TIME_W-1:0];
				num_q <= quot;
				cnt_q <= cnt_q - 1'b1;
			end
			S_MSET: begin
				// anchor and tempo are already those after this beat
				mcand_q  <= TIME_W'((now_q - anchor_q) * PHASE_SCALE);
				mplier_q <= tempo_q;
				acc_q    <= '0;
				cnt_q    <= CNT_W'(TEMPO_W - 1);
			end
			S_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[TIME_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[TEMPO_W-1:1]};
				cnt_q    <= cnt_q - 1'b1;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: load on completion, drop valid once taken
	// ------------------------------------------------------------------
	logic out_load;

	assign out_load = (state_q == S_DONE) & out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_disp_q  <= disp_q;
			out_seq_q   <= seq_q;
			out_tempo_q <= tempo_q;
			out_play_q  <= play_q;
			// product bits 31:16 are phase16; keep its top 15 bits
			out_phase_q <= acc_q[TIME_W-1:TIME_W-PHASE_W];
		end
	end

endmodule

/* test/midi_clock_tempo_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker_tb - self-checking bench of the MIDI tempo tracker
// Drives status bytes and phase queries through the valid/stall input channel,
// keeps a cycle-free model of the tracker, and compares every result beat
// field by field. A short directed pass covers filters, transport and the
// register file; a long clock run reaches lock; mixed traffic follows.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker_tb;
	import mctt_pkg::*;

	localparam int LOCK_BEATS = LOCK_BEATS_DEF;
	// Register file holds three registers; index 3 must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	// Slowest beat: the beat, the divider run, an output stall and a sender
	// gap. About 700 beats fit well inside the timeout.
	localparam int TIMEOUT_NS = 10_000_000;
	localparam int DRAIN_CYCLES = 100;

	typedef struct {
		disp_t               disp;
		logic [SEQ_W-1:0]    seq;
		logic [TEMPO_W-1:0]  tempo;
		logic                playing;
		logic [PHASE_W-1:0]  phase;
	} tracker_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 command;
	logic [SB_W-1:0]      status_byte;
	logic [TIME_W-1:0]    now_ms;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           disposition;
	logic [SEQ_W-1:0]     sequence_res;
	logic [TEMPO_W-1:0]   tempo_q88;
	logic                 playing;
	logic [PHASE_W-1:0]   phase15;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic                 cfg_data;

	// Model copy of the register file, at reset values.
	logic cfg_absorb     = 1'b0;
	logic cfg_drop_sense = 1'b1;
	logic cfg_drop_qf    = 1'b0;

	// Model copy of the tracking state.
	logic                trk_have_clock   = 1'b0;
	logic [TICK_W-1:0]   trk_ticks        = '0;
	logic [TIME_W-1:0]   trk_anchor       = '0;
	logic [TIME_W-1:0]   trk_window_start = '0;
	logic [ACQ_W-1:0]    trk_quarters     = '0;
	logic [TEMPO_W-1:0]  trk_tempo        = '0;
	logic                trk_playing      = 1'b0;
	logic [SEQ_W-1:0]    trk_seq          = '0;

	tracker_result_t expected_results[$];

	int mismatches   = 0;
	int n_items      = 0;
	int n_results    = 0;
	int n_quarters   = 0;
	int n_estimates  = 0;
	int n_saturated  = 0;
	int n_frozen     = 0;
	int n_seq_wraps  = 0;
	int n_cfg_writes = 0;
	int burst_left   = 0;
	int stall_mode   = 0;
	int stall_left   = 0;
	logic [TIME_W-1:0] clock_now = '0;

	midi_clock_tempo_tracker #(
		.LOCK_BEATS(LOCK_BEATS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.status_byte (status_byte),
		.now_ms      (now_ms),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.disposition (disposition),
		.sequence_res(sequence_res),
		.tempo_q88   (tempo_q88),
		.playing     (playing),
		.phase15     (phase15),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Mismatches found");
		$finish;
	end

	// Model of one accepted beat: update the tracking state and return the
	// result that the block must produce for it.
	function automatic tracker_result_t predict_tracker(input logic cmd,
			input logic [SB_W-1:0] sb, input logic [TIME_W-1:0] now);
		tracker_result_t r;
		logic absorbed;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] since_anchor;
		logic [63:0] quotient;
		logic [63:0] product;
		absorbed = 1'b0;
		if (cmd) begin
			r.disp = DISP_PHASE;
		end else begin
			if (cfg_absorb) begin
				absorbed = 1'b1;
				case (sb)
					SB_CLOCK: begin
						// The very first tick seeds anchor and window.
						if (!trk_have_clock) begin
							trk_have_clock   = 1'b1;
							trk_anchor       = now;
							trk_ticks        = '0;
							trk_window_start = now;
							trk_quarters     = '0;
						end
						trk_ticks = trk_ticks + 1'b1;
						if (trk_ticks >= TICKS_PER_BEAT) begin
							trk_ticks  = '0;
							trk_anchor = now;
							n_quarters++;
							if (trk_quarters < ACQ_W'(LOCK_BEATS)) begin
								trk_quarters = trk_quarters + 1'b1;
								span = now - trk_window_start;
								if (trk_quarters >= ACQ_MIN_BEATS &&
										span >= 32'(trk_quarters) * MIN_MS_PER_BEAT &&
										span <= 32'(trk_quarters) * MAX_MS_PER_BEAT) begin
									quotient = 64'(TEMPO_NUMERATOR) * 64'(trk_quarters) /
										64'(span);
									n_estimates++;
									if (quotient > 64'(TEMPO_CEILING)) begin
										trk_tempo = TEMPO_CEILING;
										n_saturated++;
									end else begin
										trk_tempo = quotient[TEMPO_W-1:0];
									end
								end
							end else begin
								n_frozen++;
							end
						end
					end
					SB_START: begin
						trk_playing      = 1'b1;
						trk_ticks        = '0;
						trk_anchor       = now;
						trk_window_start = now;
						trk_quarters     = '0;
					end
					SB_CONTINUE: trk_playing = 1'b1;
					SB_STOP:     trk_playing = 1'b0;
					default:     absorbed = 1'b0;
				endcase
			end
			if (absorbed) begin
				r.disp = DISP_ABSORB;
			end else if ((cfg_drop_sense && sb == SB_SENSING) ||
					(cfg_drop_qf && sb == SB_QFRAME)) begin
				r.disp = DISP_DROP;
			end else begin
				if (trk_seq == '1)
					n_seq_wraps++;
				trk_seq = trk_seq + 1'b1;
				r.disp = DISP_SEND;
			end
		end
		r.seq     = trk_seq;
		r.tempo   = trk_tempo;
		r.playing = trk_playing;
		if (trk_tempo == '0) begin
			r.phase = '0;
		end else begin
			since_anchor = now - trk_anchor;
			product = 64'(since_anchor) * 64'(trk_tempo) * 64'(PHASE_SCALE);
			// Keep bits 16..31 of the product, then drop the lowest.
			r.phase = product[31:17];
		end
		return r;
	endfunction

	function automatic logic [SB_W-1:0] random_status();
		if ($urandom_range(0, 9) < 4) begin
			case ($urandom_range(0, 5))
				0:       return SB_CLOCK;
				1:       return SB_START;
				2:       return SB_CONTINUE;
				3:       return SB_STOP;
				4:       return SB_SENSING;
				default: return SB_QFRAME;
			endcase
		end
		return SB_W'($urandom_range(0, 255));
	endfunction

	function automatic int tick_spacing(input int base);
		return base + $urandom_range(0, 2) - 1;
	endfunction

	// Send one beat. The sender works in bursts; between most bursts drop
	// valid for a random gap. Valid stays high after the accept so that the next
	// beat of the burst can follow back to back.
	task automatic send_beat(input logic cmd, input logic [SB_W-1:0] sb,
			input logic [TIME_W-1:0] now);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid    <= 1'b1;
		command     <= cmd;
		status_byte <= sb;
		now_ms      <= now;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(predict_tracker(cmd, sb, now));
		n_items++;
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// Write one register; cfg_valid stays high for a following write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		n_cfg_writes++;
		case (idx)
			REG_ABSORB_CLOCK: cfg_absorb     = d;
			REG_DROP_SENSING: cfg_drop_sense = d;
			REG_DROP_QFRAME:  cfg_drop_qf    = d;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic absorb, input logic drop_sense,
			input logic drop_qf);
		drain_results();
		write_reg(REG_ABSORB_CLOCK, absorb);
		write_reg(REG_DROP_SENSING, drop_sense);
		write_reg(REG_DROP_QFRAME, drop_qf);
		cfg_valid <= 1'b0;
	endtask

	// Reset settings: sensing dropped, quarter frame and sync bytes sent on.
	task automatic test_filter_defaults();
		send_beat(1'b1, 8'h00, 32'd0);
		send_beat(1'b0, SB_SENSING, 32'hFFFF_FFFF);
		send_beat(1'b0, SB_QFRAME, 32'd1);
		send_beat(1'b0, SB_CLOCK, 32'd2);
		send_beat(1'b0, SB_START, 32'd3);
		send_beat(1'b0, 8'h00, 32'd0);
		send_beat(1'b0, 8'hFF, 32'hFFFF_FFFF);
	endtask

	// Quarter-frame filter on its own, both, none; writes to the unused index.
	task automatic test_filter_settings();
		set_config(1'b0, 1'b0, 1'b1);
		send_beat(1'b0, SB_SENSING, 32'h5555_5555);
		send_beat(1'b0, SB_QFRAME, 32'hAAAA_AAAA);
		set_config(1'b0, 1'b1, 1'b1);
		send_beat(1'b0, SB_SENSING, 32'd10);
		send_beat(1'b0, SB_QFRAME, 32'd11);
		drain_results();
		write_reg(REG_UNUSED, 1'b1);
		write_reg(REG_UNUSED, 1'b0);
		cfg_valid <= 1'b0;
		send_beat(1'b0, 8'h80, 32'd12);
		set_config(1'b0, 1'b0, 1'b0);
		send_beat(1'b0, SB_SENSING, 32'd13);
		send_beat(1'b0, SB_QFRAME, 32'd14);
	endtask

	// Transport bytes with absorb on; other bytes still go through.
	task automatic test_transport();
		set_config(1'b1, 1'b0, 1'b0);
		send_beat(1'b0, SB_CONTINUE, 32'd100);
		send_beat(1'b0, SB_STOP, 32'd200);
		send_beat(1'b0, SB_START, 32'd300);
		send_beat(1'b0, SB_SENSING, 32'd400);
		send_beat(1'b0, SB_QFRAME, 32'd500);
		send_beat(1'b1, 8'hFF, 32'd600);
		send_beat(1'b0, 8'h90, 32'd700);
	endtask

	// Start, then a clock stream from just below the 32-bit timestamp wrap. The first
	// two quarter notes span exactly the minimum window, so the estimate
	// saturates; the stream then runs two quarter notes past lock.
	task automatic test_tempo_lock();
		logic [TIME_W-1:0] t0;
		logic [TIME_W-1:0] t;
		int spacing;
		set_config(1'b1, 1'b1, 1'b1);
		t0 = 32'hFFFF_F000 + $urandom_range(0, 255);
		send_beat(1'b0, SB_START, t0 - 32'd7);
		for (int k = 0; k < 48; k++)
			send_beat(1'b0, SB_CLOCK, t0 + 32'((k * 450) / 47));
		t = t0 + 32'd450;
		spacing = $urandom_range(10, 125);
		for (int k = 48; k < (LOCK_BEATS + 2) * 24; k++) begin
			if (k % 20 == 0)
				send_beat(1'b1, SB_W'($urandom_range(0, 255)),
					t + 32'($urandom_range(0, 400)));
			t = t + 32'(tick_spacing(spacing));
			send_beat(1'b0, SB_CLOCK, t);
		end
		clock_now = t;
	endtask

	// Alternate clock runs at random tempo (some outside the legal window,
	// some with start mid-run, some with absorb off) with noise episodes
	// under random register settings.
	task automatic test_mixed_traffic();
		int spacing;
		int count;
		logic cmd;
		logic [TIME_W-1:0] now;
		while (n_items < 600) begin
			if ($urandom_range(0, 1) == 0) begin
				if ($urandom_range(0, 2) == 0 || !cfg_absorb)
					set_config($urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
				case ($urandom_range(0, 9))
					0:       spacing = $urandom_range(7, 9);
					1:       spacing = $urandom_range(126, 140);
					default: spacing = $urandom_range(10, 125);
				endcase
				if ($urandom_range(0, 1) == 0)
					send_beat(1'b0, SB_START, clock_now);
				count = $urandom_range(6, 72);
				for (int k = 0; k < count; k++) begin
					if ($urandom_range(0, 7) == 0) begin
						send_beat($urandom_range(0, 2) == 0, random_status(),
							clock_now + 32'($urandom_range(0, 3000)));
					end else begin
						if ($urandom_range(0, 149) == 0)
							clock_now = clock_now + 32'($urandom_range(1000, 200000));
						clock_now = clock_now + 32'(tick_spacing(spacing));
						send_beat(1'b0, SB_CLOCK, clock_now);
					end
					if ($urandom_range(0, 99) == 0)
						drain_results();
				end
			end else begin
				set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
				count = $urandom_range(8, 40);
				for (int k = 0; k < count; k++) begin
					cmd = ($urandom_range(0, 7) == 0);
					now = ($urandom_range(0, 1) == 0) ? TIME_W'($urandom) :
						clock_now + 32'($urandom_range(0, 5000));
					send_beat(cmd, random_status(), now);
				end
			end
		end
	endtask

	// Receiver stall pattern: switch between free flow, light and heavy
	// random stalls, and a periodic long stall.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_left <= $urandom_range(16, 160);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(0, 3) == 0);
			2:       out_stall <= ($urandom_range(0, 9) < 7);
			default: out_stall <= ((stall_left % 32) < 22);
		endcase
	end

	// Compare each accepted result beat with the oldest expectation.
	always @(posedge clk) begin
		tracker_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				$error("result with nothing expected: disposition %0d", disposition);
			end else begin
				want = expected_results.pop_front();
				n_results++;
				if (disposition !== want.disp) begin
					mismatches++;
					$error("disposition: expected %0d, got %0d", want.disp, disposition);
				end
				if (sequence_res !== want.seq) begin
					mismatches++;
					$error("sequence_res: expected %0d, got %0d", want.seq, sequence_res);
				end
				if (tempo_q88 !== want.tempo) begin
					mismatches++;
					$error("tempo_q88: expected %0d, got %0d", want.tempo, tempo_q88);
				end
				if (playing !== want.playing) begin
					mismatches++;
					$error("playing: expected %0d, got %0d", want.playing, playing);
				end
				if (phase15 !== want.phase) begin
					mismatches++;
					$error("phase15: expected %0d, got %0d", want.phase, phase15);
				end
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		command     = 1'b0;
		status_byte = '0;
		now_ms      = '0;
		cfg_valid   = 1'b0;
		cfg_index   = '0;
		cfg_data    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_filter_defaults();
		test_filter_settings();
		test_transport();
		test_tempo_lock();
		test_mixed_traffic();

		// Drain, then watch for stray results.
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d input beats, checked %0d results, %0d register writes.",
			n_items, n_results, n_cfg_writes);
		$display("%0d quarter notes, %0d estimates (%0d saturated), %0d after lock, %0d seq wraps.",
			n_quarters, n_estimates, n_saturated, n_frozen, n_seq_wraps);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
